FILE: rtl/lpht_pkg.sv
// Package of types, constants and codes shared by the hash table modules.
package lpht_pkg;

	localparam int TABLE_SIZE_DEF  = 16;
	localparam int KEY_BYTES_DEF   = 8;
	localparam int RECORD_BITS_DEF = 16;

	localparam int KEY_W         = 64;
	localparam int REC_W         = 16;
	localparam int MODE_W        = 2;
	localparam int STATUS_W      = 2;
	localparam int HASH_BITS     = 32;
	localparam int MOD_STEP_BITS = 4;
	localparam int MOD_STEPS     = HASH_BITS / MOD_STEP_BITS;
	localparam int MOD_CNT_W     = $clog2(MOD_STEPS);

	typedef enum logic [MODE_W-1:0] {
		MODE_INSERT = 2'd0,
		MODE_LOOKUP = 2'd1,
		MODE_DELETE = 2'd2
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		MARK_EMPTY   = 2'd0,
		MARK_USED    = 2'd1,
		MARK_DELETED = 2'd2
	} mark_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_HASH,
		S_MOD,
		S_READ,
		S_CHECK,
		S_RESULT
	} state_t;

	typedef struct packed {
		logic    load;
		logic    hash_step;
		logic    mod_step;
		logic    probe_start;
		logic    probe_next;
		logic    clear_step;
		logic    wr_mark;
		mark_t   wr_mark_val;
		logic    wr_data;
		logic    pend_load;
		status_t pend_status;
		logic    pend_rec_sel;
		logic    res_load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic              hash_done;
		logic              mod_last;
		logic              slot_last;
		logic              probe_last;
		logic [MODE_W-1:0] mode;
		mark_t             mark;
		logic              key_match;
	} dp_stat_t;

endpackage

FILE: rtl/lpht_req_if.sv
// Request channel interface: operation, key and record handle.
interface lpht_req_if;
	logic                         valid;
	logic                         ready;
	logic [lpht_pkg::MODE_W-1:0]  mode;
	logic [lpht_pkg::KEY_W-1:0]   key;
	logic [lpht_pkg::REC_W-1:0]   record_in;

	modport source(output valid, mode, key, record_in, input ready);
	modport sink(input valid, mode, key, record_in, output ready);
endinterface

FILE: rtl/lpht_rsp_if.sv
// Response channel interface: status and record handle.
interface lpht_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [lpht_pkg::STATUS_W-1:0] status;
	logic [lpht_pkg::REC_W-1:0]    record_out;

	modport source(output valid, status, record_out, input ready);
	modport sink(input valid, status, record_out, output ready);
endinterface

FILE: rtl/lpht_datapath.sv
// Datapath of the hash table: key cut, hash, modulo reduction, slot memories and result.
module lpht_datapath #(
	parameter int TABLE_SIZE  = lpht_pkg::TABLE_SIZE_DEF,
	parameter int KEY_BYTES   = lpht_pkg::KEY_BYTES_DEF,
	parameter int RECORD_BITS = lpht_pkg::RECORD_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lpht_pkg::ctrl_cmd_t           cmd,
	output lpht_pkg::dp_stat_t            stat,
	input  logic [lpht_pkg::MODE_W-1:0]   mode,
	input  logic [lpht_pkg::KEY_W-1:0]    key,
	input  logic [lpht_pkg::REC_W-1:0]    record_in,
	output logic [lpht_pkg::STATUS_W-1:0] status,
	output logic [lpht_pkg::REC_W-1:0]    record_out
);

	localparam int SW = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
	localparam int KW = 8 * KEY_BYTES;
	localparam int LW = $clog2(KEY_BYTES + 1);
	localparam logic [SW:0]   TS_W    = (SW + 1)'(TABLE_SIZE);
	localparam logic [SW-1:0] TS_LAST = SW'(TABLE_SIZE - 1);

	lpht_pkg::mark_t  mark_mem [TABLE_SIZE];
	logic [KW-1:0]    key_mem  [TABLE_SIZE];
	logic [RECORD_BITS-1:0] rec_mem [TABLE_SIZE];

	lpht_pkg::mark_t        mark_rd_q;
	logic [KW-1:0]          key_rd_q;
	logic [RECORD_BITS-1:0] rec_rd_q;

	logic [lpht_pkg::MODE_W-1:0]    mode_q;
	logic [KW-1:0]                  key_q;
	logic [KW-1:0]                  key_sh_q;
	logic [RECORD_BITS-1:0]         rec_q;
	logic [lpht_pkg::HASH_BITS-1:0] hash_q;
	logic [SW-1:0]                  rem_q;
	logic [LW-1:0]                  bytes_q;
	logic [lpht_pkg::MOD_CNT_W-1:0] mod_cnt_q;
	logic [SW-1:0]                  slot_q;
	logic [SW-1:0]                  probe_cnt_q;

	lpht_pkg::status_t              pend_status_q;
	logic [lpht_pkg::REC_W-1:0]     pend_rec_q;
	logic [lpht_pkg::STATUS_W-1:0]  res_status_q;
	logic [lpht_pkg::REC_W-1:0]     res_rec_q;

	logic [KW-1:0]                  cut_key;
	logic [LW-1:0]                  cut_len;
	logic [SW-1:0]                  rem_nxt;
	logic [SW-1:0]                  slot_nxt;
	logic [lpht_pkg::HASH_BITS-1:0] sx;

	// The key keeps the bytes before its first zero byte.
	always_comb begin
		logic       alive;
		logic [7:0] b;
		alive   = 1'b1;
		cut_key = '0;
		cut_len = '0;
		for (int n = 0; n < KEY_BYTES; n++) begin
			b = key[8*n +: 8];
			if (alive && (b != 8'd0)) begin
				cut_key[8*n +: 8] = b;
				cut_len           = cut_len + LW'(1);
			end else begin
				alive = 1'b0;
			end
		end
	end

	assign sx = {{(lpht_pkg::HASH_BITS - 8){key_sh_q[7]}}, key_sh_q[7:0]};

	// Restoring remainder by the table size, several hash bits per cycle.
	always_comb begin
		logic [SW-1:0] r;
		logic [SW:0]   t;
		r = rem_q;
		for (int j = 0; j < lpht_pkg::MOD_STEP_BITS; j++) begin
			t = {r, hash_q[lpht_pkg::HASH_BITS-1-j]};
			if (t >= TS_W) begin
				t = t - TS_W;
			end
			r = t[SW-1:0];
		end
		rem_nxt = r;
	end

	assign slot_nxt = (slot_q == TS_LAST) ? '0 : slot_q + SW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_q     <= '0;
			mod_cnt_q   <= '0;
			slot_q      <= '0;
			probe_cnt_q <= '0;
		end else begin
			if (cmd.load) begin
				bytes_q   <= cut_len;
				mod_cnt_q <= '0;
			end else if (cmd.hash_step) begin
				bytes_q <= bytes_q - LW'(1);
			end else if (cmd.mod_step) begin
				mod_cnt_q <= mod_cnt_q + lpht_pkg::MOD_CNT_W'(1);
			end
			if (cmd.probe_start) begin
				slot_q      <= rem_nxt;
				probe_cnt_q <= '0;
			end else if (cmd.probe_next || cmd.clear_step) begin
				slot_q      <= slot_nxt;
				probe_cnt_q <= probe_cnt_q + SW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q   <= mode;
			key_q    <= cut_key;
			key_sh_q <= cut_key;
			rec_q    <= RECORD_BITS'(record_in);
			hash_q   <= '0;
			rem_q    <= '0;
		end else if (cmd.hash_step) begin
			hash_q   <= lpht_pkg::HASH_BITS'((hash_q + sx) * sx);
			key_sh_q <= key_sh_q >> 8;
		end else if (cmd.mod_step) begin
			hash_q <= hash_q << lpht_pkg::MOD_STEP_BITS;
			rem_q  <= rem_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_mark) begin
			mark_mem[slot_q] <= cmd.wr_mark_val;
		end
		if (cmd.wr_data) begin
			key_mem[slot_q] <= key_q;
			rec_mem[slot_q] <= rec_q;
		end
		mark_rd_q <= mark_mem[slot_q];
		key_rd_q  <= key_mem[slot_q];
		rec_rd_q  <= rec_mem[slot_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.pend_load) begin
			pend_status_q <= cmd.pend_status;
			pend_rec_q    <= cmd.pend_rec_sel ? lpht_pkg::REC_W'(rec_rd_q) : '0;
		end
		if (cmd.res_load) begin
			res_status_q <= pend_status_q;
			res_rec_q    <= pend_rec_q;
		end
	end

	assign stat.hash_done  = (bytes_q == '0);
	assign stat.mod_last   = (mod_cnt_q == lpht_pkg::MOD_CNT_W'(lpht_pkg::MOD_STEPS - 1));
	assign stat.slot_last  = (slot_q == TS_LAST);
	assign stat.probe_last = (probe_cnt_q == TS_LAST);
	assign stat.mode       = mode_q;
	assign stat.mark       = mark_rd_q;
	assign stat.key_match  = (key_rd_q == key_q);

	assign status     = res_status_q;
	assign record_out = res_rec_q;

endmodule

FILE: rtl/lpht_ctrl.sv
// Controller state machine of the hash table: sequences the slot clear after reset, hashing, probing and the response.
module lpht_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	input  lpht_pkg::dp_stat_t  stat,
	output lpht_pkg::ctrl_cmd_t cmd
);

	lpht_pkg::state_t state_q, state_nxt;
	logic             rsp_valid_q, rsp_valid_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lpht_pkg::S_CLEAR;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_nxt;
			rsp_valid_q <= rsp_valid_nxt;
		end
	end

	always_comb begin
		state_nxt     = state_q;
		cmd           = '0;
		cmd.wr_mark_val = lpht_pkg::MARK_EMPTY;
		cmd.pend_status = lpht_pkg::ST_NOT_FOUND;
		req_ready     = 1'b0;
		rsp_valid_nxt = rsp_valid_q && !rsp_ready;

		case (state_q)
			lpht_pkg::S_CLEAR: begin
				cmd.wr_mark     = 1'b1;
				cmd.wr_mark_val = lpht_pkg::MARK_EMPTY;
				cmd.clear_step  = 1'b1;
				if (stat.slot_last) begin
					state_nxt = lpht_pkg::S_IDLE;
				end
			end
			lpht_pkg::S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load  = 1'b1;
					state_nxt = lpht_pkg::S_HASH;
				end
			end
			lpht_pkg::S_HASH: begin
				if (stat.hash_done) begin
					state_nxt = lpht_pkg::S_MOD;
				end else begin
					cmd.hash_step = 1'b1;
				end
			end
			lpht_pkg::S_MOD: begin
				cmd.mod_step = 1'b1;
				if (stat.mod_last) begin
					cmd.probe_start = 1'b1;
					state_nxt       = lpht_pkg::S_READ;
				end
			end
			lpht_pkg::S_READ: begin
				state_nxt = lpht_pkg::S_CHECK;
			end
			lpht_pkg::S_CHECK: begin
				case (stat.mode)
					lpht_pkg::MODE_INSERT: begin
						if (stat.mark != lpht_pkg::MARK_USED) begin
							cmd.wr_mark     = 1'b1;
							cmd.wr_mark_val = lpht_pkg::MARK_USED;
							cmd.wr_data     = 1'b1;
							cmd.pend_load   = 1'b1;
							cmd.pend_status = lpht_pkg::ST_OK;
							state_nxt       = lpht_pkg::S_RESULT;
						end else if (stat.probe_last) begin
							cmd.pend_load   = 1'b1;
							cmd.pend_status = lpht_pkg::ST_FULL;
							state_nxt       = lpht_pkg::S_RESULT;
						end else begin
							cmd.probe_next = 1'b1;
							state_nxt      = lpht_pkg::S_READ;
						end
					end
					lpht_pkg::MODE_LOOKUP, lpht_pkg::MODE_DELETE: begin
						if (stat.mark == lpht_pkg::MARK_EMPTY) begin
							cmd.pend_load   = 1'b1;
							cmd.pend_status = lpht_pkg::ST_NOT_FOUND;
							state_nxt       = lpht_pkg::S_RESULT;
						end else if ((stat.mark == lpht_pkg::MARK_USED) && stat.key_match) begin
							cmd.pend_load    = 1'b1;
							cmd.pend_status  = lpht_pkg::ST_OK;
							cmd.pend_rec_sel = 1'b1;
							if (stat.mode == lpht_pkg::MODE_DELETE) begin
								cmd.wr_mark     = 1'b1;
								cmd.wr_mark_val = lpht_pkg::MARK_DELETED;
							end
							state_nxt = lpht_pkg::S_RESULT;
						end else if (stat.probe_last) begin
							cmd.pend_load   = 1'b1;
							cmd.pend_status = lpht_pkg::ST_NOT_FOUND;
							state_nxt       = lpht_pkg::S_RESULT;
						end else begin
							cmd.probe_next = 1'b1;
							state_nxt      = lpht_pkg::S_READ;
						end
					end
					default: begin
						cmd.pend_load   = 1'b1;
						cmd.pend_status = lpht_pkg::ST_NOT_FOUND;
						state_nxt       = lpht_pkg::S_RESULT;
					end
				endcase
			end
			lpht_pkg::S_RESULT: begin
				if (!rsp_valid_q || rsp_ready) begin
					cmd.res_load  = 1'b1;
					rsp_valid_nxt = 1'b1;
					state_nxt     = lpht_pkg::S_IDLE;
				end
			end
			default: begin
				state_nxt = lpht_pkg::S_IDLE;
			end
		endcase
	end

	assign rsp_valid = rsp_valid_q;

endmodule

FILE: rtl/linear_probe_hash_table_top.sv
// Top level of the open-addressing hash table with linear probing and tombstones.
//
//   channel  direction  transaction carries
//   req      in         mode, key, record_in
//   rsp      out        status, record_out
//
// A transaction goes from acceptance to the response register through the byte-wise hash
// over the L key bytes, the four-bit-per-cycle remainder unit and, for each of the P slots
// probed (1 to TABLE_SIZE), a registered slot memory read and a check; L is the key length
// in bytes.
// After reset the slot marks are cleared slot by slot before req becomes ready.
// The response register lets a new transaction be accepted while a result awaits rsp.ready.
module linear_probe_hash_table_top #(
	parameter int TABLE_SIZE  = lpht_pkg::TABLE_SIZE_DEF,
	parameter int KEY_BYTES   = lpht_pkg::KEY_BYTES_DEF,
	parameter int RECORD_BITS = lpht_pkg::RECORD_BITS_DEF
) (
	input logic        clk,
	input logic        arst_n,
	lpht_req_if.sink   req,
	lpht_rsp_if.source rsp
);

	lpht_pkg::ctrl_cmd_t cmd;
	lpht_pkg::dp_stat_t  stat;
	logic                req_ready;
	logic                rsp_valid;

	lpht_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	lpht_datapath #(
		.TABLE_SIZE  (TABLE_SIZE),
		.KEY_BYTES   (KEY_BYTES),
		.RECORD_BITS (RECORD_BITS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.mode       (req.mode),
		.key        (req.key),
		.record_in  (req.record_in),
		.status     (rsp.status),
		.record_out (rsp.record_out)
	);

	assign req.ready = req_ready;
	assign rsp.valid = rsp_valid;

endmodule

FILE: test/linear_probe_hash_table_top_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench of the linear probing hash table, with a scoreboard that predicts each response.
module linear_probe_hash_table_top_tb;

	localparam int     SLOTS        = lpht_pkg::TABLE_SIZE_DEF;
	localparam int     KEY_LEN_MAX  = lpht_pkg::KEY_BYTES_DEF;
	localparam int     RANDOM_ITEMS = 1950;
	localparam int     KEY_POOL     = 32;
	localparam int     SETTLE       = 4 + KEY_LEN_MAX + 8 + 2 * SLOTS + 8;
	localparam longint CYCLE_LIMIT  = 1000000;

	localparam logic [lpht_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;

	typedef struct packed {
		lpht_pkg::status_t          status;
		logic [lpht_pkg::REC_W-1:0] rec;
	} answer_t;

	class hash_table_scoreboard;
		lpht_pkg::mark_t            shadow_mark[SLOTS];
		logic [lpht_pkg::KEY_W-1:0] shadow_key[SLOTS];
		logic [lpht_pkg::REC_W-1:0] shadow_rec[SLOTS];
		answer_t                    answers_due[$];
		int                         failures;

		function new();
			foreach (shadow_mark[i]) begin
				shadow_mark[i] = lpht_pkg::MARK_EMPTY;
				shadow_key[i]  = '0;
				shadow_rec[i]  = '0;
			end
			failures = 0;
		endfunction

		function answer_t predict_answer(logic [lpht_pkg::MODE_W-1:0] op,
				logic [lpht_pkg::KEY_W-1:0] raw, logic [lpht_pkg::REC_W-1:0] rec_in);
			logic [lpht_pkg::KEY_W-1:0] cut;
			logic [31:0]                hash;
			logic [31:0]                sx;
			int                         len;
			int                         start;
			int                         s;
			int                         i;
			bit                         done;
			answer_t                    ans;
			cut  = '0;
			len  = 0;
			hash = '0;
			while (len < KEY_LEN_MAX && raw[8*len +: 8] != 8'd0) begin
				cut[8*len +: 8] = raw[8*len +: 8];
				len++;
			end
			for (i = 0; i < len; i++) begin
				sx   = {{24{cut[8*i+7]}}, cut[8*i +: 8]};
				hash = (hash + sx) * sx;
			end
			start      = int'(hash % SLOTS);
			ans.status = lpht_pkg::ST_NOT_FOUND;
			ans.rec    = '0;
			done       = 1'b0;
			if (op == lpht_pkg::MODE_INSERT) begin
				ans.status = lpht_pkg::ST_FULL;
				for (i = 0; i < SLOTS && !done; i++) begin
					s = (start + i) % SLOTS;
					if (shadow_mark[s] != lpht_pkg::MARK_USED) begin
						shadow_mark[s] = lpht_pkg::MARK_USED;
						shadow_key[s]  = cut;
						shadow_rec[s]  = rec_in;
						ans.status     = lpht_pkg::ST_OK;
						done           = 1'b1;
					end
				end
			end else if (op == lpht_pkg::MODE_LOOKUP || op == lpht_pkg::MODE_DELETE) begin
				for (i = 0; i < SLOTS && !done; i++) begin
					s = (start + i) % SLOTS;
					if (shadow_mark[s] == lpht_pkg::MARK_EMPTY) begin
						done = 1'b1;
					end else if (shadow_mark[s] == lpht_pkg::MARK_USED
							&& shadow_key[s] == cut) begin
						ans.status = lpht_pkg::ST_OK;
						ans.rec    = shadow_rec[s];
						if (op == lpht_pkg::MODE_DELETE) begin
							shadow_mark[s] = lpht_pkg::MARK_DELETED;
						end
						done = 1'b1;
					end
				end
			end
			return ans;
		endfunction

		function void note_request(logic [lpht_pkg::MODE_W-1:0] op,
				logic [lpht_pkg::KEY_W-1:0] raw, logic [lpht_pkg::REC_W-1:0] rec_in);
			answers_due.push_back(predict_answer(op, raw, rec_in));
		endfunction

		function void check_response(logic [lpht_pkg::STATUS_W-1:0] status,
				logic [lpht_pkg::REC_W-1:0] rec);
			answer_t due;
			if (answers_due.size() == 0) begin
				$error("unexpected transaction: status %0d, record_out %h", status, rec);
				failures++;
			end else begin
				due = answers_due.pop_front();
				if (status !== due.status) begin
					$error("status: expected %0d, actual %0d", due.status, status);
					failures++;
				end
				if (rec !== due.rec) begin
					$error("record_out: expected %h, actual %h", due.rec, rec);
					failures++;
				end
			end
		endfunction
	endclass

	logic                       clk = 1'b0;
	logic                       arst_n;
	longint                     cycle_count = 0;
	logic [lpht_pkg::KEY_W-1:0] key_pool[KEY_POOL];
	hash_table_scoreboard       sb = new();

	lpht_req_if req();
	lpht_rsp_if rsp();

	linear_probe_hash_table_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp.valid && rsp.ready) begin
				sb.check_response(rsp.status, rsp.record_out);
			end
			if (req.valid && req.ready) begin
				sb.note_request(req.mode, req.key, req.record_in);
			end
		end
	end

	function automatic logic [lpht_pkg::KEY_W-1:0] make_key();
		logic [lpht_pkg::KEY_W-1:0] k;
		int                         len;
		int                         i;
		k   = '0;
		len = $urandom_range(0, KEY_LEN_MAX);
		for (i = 0; i < len; i++) begin
			k[8*i +: 8] = 8'($urandom_range(1, 255));
		end
		return k;
	endfunction

	function automatic logic [lpht_pkg::KEY_W-1:0] scramble_tail(
			logic [lpht_pkg::KEY_W-1:0] k);
		logic [lpht_pkg::KEY_W-1:0] dressed;
		int                         p;
		int                         i;
		dressed = k;
		p       = 0;
		while (p < KEY_LEN_MAX && k[8*p +: 8] != 8'd0) begin
			p++;
		end
		for (i = p + 1; i < KEY_LEN_MAX; i++) begin
			dressed[8*i +: 8] = 8'($urandom_range(0, 255));
		end
		return dressed;
	endfunction

	task automatic pick_item(output logic [lpht_pkg::MODE_W-1:0] op,
			output logic [lpht_pkg::KEY_W-1:0] raw,
			output logic [lpht_pkg::REC_W-1:0] rec_in);
		int choice;
		choice = $urandom_range(0, 99);
		if ($urandom_range(0, 39) == 0) begin
			key_pool[$urandom_range(0, KEY_POOL - 1)] = make_key();
		end
		raw    = scramble_tail(key_pool[$urandom_range(0, KEY_POOL - 1)]);
		rec_in = 16'($urandom_range(0, 65535));
		if (choice < 35) begin
			op = lpht_pkg::MODE_INSERT;
		end else if (choice < 65) begin
			op = lpht_pkg::MODE_LOOKUP;
		end else if (choice < 93) begin
			op = lpht_pkg::MODE_DELETE;
		end else if (choice < 96) begin
			op = MODE_UNUSED;
		end else begin
			op  = 2'($urandom_range(0, 3));
			raw = {$urandom, $urandom};
		end
	endtask

	task automatic send_request(logic [lpht_pkg::MODE_W-1:0] op,
			logic [lpht_pkg::KEY_W-1:0] raw, logic [lpht_pkg::REC_W-1:0] rec_in);
		req.valid     <= 1'b1;
		req.mode      <= op;
		req.key       <= raw;
		req.record_in <= rec_in;
		@(posedge clk);
		while (!req.ready) begin
			@(posedge clk);
		end
	endtask

	initial begin : rsp_stall_pattern
		int run;
		rsp.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			run = $urandom_range(1, 40);
			rsp.ready <= 1'b1;
			repeat (run) @(posedge clk);
			if ($urandom_range(0, 3) != 0) begin
				rsp.ready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
	end

	initial begin : stimulus
		logic [lpht_pkg::MODE_W-1:0] op;
		logic [lpht_pkg::KEY_W-1:0]  raw;
		logic [lpht_pkg::REC_W-1:0]  rec_in;
		int                          sent;
		int                          burst;
		int                          i;
		arst_n        <= 1'b0;
		req.valid     <= 1'b0;
		req.mode      <= lpht_pkg::MODE_INSERT;
		req.key       <= '0;
		req.record_in <= '0;
		foreach (key_pool[j]) begin
			key_pool[j] = make_key();
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_request(lpht_pkg::MODE_LOOKUP, 64'h0000_0000_0000_0041, 16'h0000);
		send_request(lpht_pkg::MODE_INSERT, 64'h0000_0000_0000_0000, 16'hFFFF);
		send_request(lpht_pkg::MODE_LOOKUP, 64'hFFFF_FFFF_FFFF_FF00, 16'h0000);
		send_request(lpht_pkg::MODE_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 16'h0000);
		send_request(lpht_pkg::MODE_INSERT, 64'h0000_0000_0000_0001, 16'h1234);
		send_request(lpht_pkg::MODE_INSERT, 64'h5A5A_5A5A_5A5A_0001, 16'h5678);
		send_request(lpht_pkg::MODE_LOOKUP, 64'h0000_0000_0000_0001, 16'hFFFF);
		send_request(lpht_pkg::MODE_DELETE, 64'hFFFF_FFFF_FF00_0001, 16'h0000);
		send_request(lpht_pkg::MODE_LOOKUP, 64'h0000_0000_0000_0001, 16'h0000);
		send_request(MODE_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF);
		// Fill every remaining slot, then insert once more into the full table.
		for (i = 0; i < SLOTS - 2; i++) begin
			send_request(lpht_pkg::MODE_INSERT, key_pool[i], 16'($urandom_range(0, 65535)));
		end
		// With no empty slot left, a miss has to sweep the whole table.
		send_request(lpht_pkg::MODE_LOOKUP, 64'h7F80_7F80_7F80_7F80, 16'h0000);

		req.valid <= 1'b0;
		while (sb.answers_due.size() != 0) begin
			@(posedge clk);
		end

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			burst = $urandom_range(1, 12);
			repeat (burst) begin
				pick_item(op, raw, rec_in);
				send_request(op, raw, rec_in);
				if (op != MODE_UNUSED) begin
					sent++;
				end
			end
			if ($urandom_range(0, 2) != 0) begin
				req.valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end

		req.valid <= 1'b0;
		while (sb.answers_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE) @(posedge clk);
		if (sb.failures == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

FILE: filelist.f
rtl/lpht_pkg.sv
rtl/lpht_req_if.sv
rtl/lpht_rsp_if.sv
rtl/lpht_datapath.sv
rtl/lpht_ctrl.sv
rtl/linear_probe_hash_table_top.sv
test/linear_probe_hash_table_top_tb.sv
